[rtl/tkd_pkg.sv]
`timescale 1ns / 1ps

package tkd_pkg;

    // Decoded key kinds
    typedef enum logic [3:0] {
        KEY_CHAR   = 4'd0,
        KEY_ESCAPE = 4'd1,
        KEY_BKSP   = 4'd2,
        KEY_UP     = 4'd3,
        KEY_DOWN   = 4'd4,
        KEY_RIGHT  = 4'd5,
        KEY_LEFT   = 4'd6,
        KEY_HOME   = 4'd7,
        KEY_END    = 4'd8,
        KEY_INS    = 4'd9,
        KEY_DEL    = 4'd10,
        KEY_PGUP   = 4'd11,
        KEY_PGDN   = 4'd12,
        KEY_FN     = 4'd13,
        KEY_IGN    = 4'd14,
        KEY_ERR    = 4'd15
    } key_kind_t;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_ESC      = 8'b0000_0010,
        PH_ALT      = 8'b0000_0100,
        PH_INTRO    = 8'b0000_1000,
        PH_DIGIT    = 8'b0001_0000,
        PH_TAIL     = 8'b0010_0000,
        PH_BRACKET2 = 8'b0100_0000,
        PH_UTF8     = 8'b1000_0000
    } phase_t;

    // Key produced by a final byte of an escape sequence
    typedef struct packed {
        key_kind_t   kind;
        logic [3:0]  fn;
    } key_t;

    // Bundle of candidate keys from the sequence mapper
    typedef struct packed {
        key_t letter;
        key_t tilde;
        key_t tail;
        key_t bracket;
    } seq_keys_t;

    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_UPPER_O = 8'h4F;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    // Offset removed from the gathered UTF-8 bits, by sequence length
    function automatic logic [31:0] utf8_offset(input logic [2:0] len);
        logic [31:0] off;
        case (len)
            3'd2:    off = 32'h0000_3080;
            3'd3:    off = 32'h000E_2080;
            3'd4:    off = 32'h03C8_2080;
            3'd5:    off = 32'hFA08_2080;
            3'd6:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

[rtl/tkd_seq_map.sv]
`timescale 1ns / 1ps

module tkd_seq_map (
    input  logic [7:0]         byte_in,
    input  logic               intro_o,
    input  logic [7:0]         digit_byte,
    input  logic [7:0]         second_digit,
    output tkd_pkg::seq_keys_t keys
);
    import tkd_pkg::*;

    logic [3:0] sec_idx;
    logic [3:0] tail_fn;
    key_t       letter_key;
    key_t       tilde_key;
    key_t       tail_key;
    key_t       bracket_key;

    // Map a final letter after ESC [ or ESC O
    always_comb begin
        letter_key.fn = 4'd0;
        case (byte_in)
            8'h41: letter_key.kind = KEY_UP;
            8'h42: letter_key.kind = KEY_DOWN;
            8'h43: letter_key.kind = KEY_RIGHT;
            8'h44: letter_key.kind = KEY_LEFT;
            8'h48: letter_key.kind = KEY_HOME;
            8'h46: letter_key.kind = KEY_END;
            8'h50: begin
                letter_key.kind = intro_o ? KEY_FN : KEY_DEL;
                letter_key.fn   = intro_o ? 4'd1 : 4'd0;
            end
            8'h51, 8'h52, 8'h53: begin
                letter_key.kind = intro_o ? KEY_FN : KEY_IGN;
                letter_key.fn   = intro_o ? (byte_in[3:0] + 4'd1) : 4'd0;
            end
            default: letter_key.kind = KEY_IGN;
        endcase
    end

    // Map ESC [ digit ~
    always_comb begin
        tilde_key.fn = 4'd0;
        case (digit_byte)
            8'h31, 8'h37: tilde_key.kind = KEY_HOME;
            8'h32:        tilde_key.kind = KEY_INS;
            8'h33:        tilde_key.kind = KEY_DEL;
            8'h34, 8'h38: tilde_key.kind = KEY_END;
            8'h35:        tilde_key.kind = KEY_PGUP;
            8'h36:        tilde_key.kind = KEY_PGDN;
            default:      tilde_key.kind = KEY_IGN;
        endcase
    end

    // Map ESC [ 1x / 2x to a function key number
    assign sec_idx = second_digit[3:0];

    always_comb begin
        tail_fn = 4'd0;
        if (second_digit >= 8'h30 && second_digit <= 8'h39) begin
            if (digit_byte == 8'h31) begin
                case (sec_idx)
                    4'd1:    tail_fn = 4'd1;
                    4'd2:    tail_fn = 4'd2;
                    4'd3:    tail_fn = 4'd3;
                    4'd4:    tail_fn = 4'd4;
                    4'd5:    tail_fn = 4'd5;
                    4'd7:    tail_fn = 4'd6;
                    4'd8:    tail_fn = 4'd7;
                    4'd9:    tail_fn = 4'd8;
                    default: tail_fn = 4'd0;
                endcase
            end else begin
                case (sec_idx)
                    4'd0:    tail_fn = 4'd9;
                    4'd1:    tail_fn = 4'd10;
                    4'd3:    tail_fn = 4'd11;
                    4'd4:    tail_fn = 4'd12;
                    default: tail_fn = 4'd0;
                endcase
            end
        end
        tail_key.kind = (tail_fn == 4'd0) ? KEY_IGN : KEY_FN;
        tail_key.fn   = tail_fn;
    end

    // Map ESC [ [ A-E (linux console F1-F5)
    always_comb begin
        if (byte_in >= 8'h41 && byte_in <= 8'h45) begin
            bracket_key.kind = KEY_FN;
            bracket_key.fn   = byte_in[3:0];
        end else begin
            bracket_key.kind = KEY_IGN;
            bracket_key.fn   = 4'd0;
        end
    end

    // Bundle the candidate keys
    assign keys = {letter_key, tilde_key, tail_key, bracket_key};

endmodule

[rtl/terminal_key_decoder.sv]
`timescale 1ns / 1ps

// Terminal key decoder. Each transfer on the s_ side is either a received byte
// (s_operation = 0) or a receive timeout tick (s_operation = 1); each gives at
// most one decoded key on the m_ side. Escape sequences (xterm, rxvt, linux),
// a lone ESC ended by a timeout, byte 127 as backspace and multi-byte UTF-8
// are recognized. The block takes one transfer per clock: the parser advances
// on each transfer, and the key appears in the output register in the cycle
// after the transfer that completes it. s_ready stays high while the output
// register is empty or being drained, so a stalled m_ side stalls input.
module terminal_key_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_key_kind,
    output logic [30:0] m_code_point,
    output logic [3:0]  m_function_number
);
    import tkd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        intro_o_reg, intro_o_next;
    logic [7:0]  digit_reg, digit_next;
    logic [7:0]  second_reg, second_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;
    logic        invalid_reg, invalid_next;

    logic        out_valid_reg, out_valid_next;
    key_kind_t   kind_reg, kind_next;
    logic [30:0] cp_reg, cp_next;
    logic [3:0]  fn_reg, fn_next;

    logic        accept;
    logic        timeout;
    logic [7:0]  b;
    logic        emit;
    key_kind_t   emit_kind;
    logic [30:0] emit_cp;
    logic [3:0]  emit_fn;
    logic        idle_work;
    logic [31:0] acc_shift;
    logic [31:0] cp_full;
    logic [2:0]  rem_dec;
    logic [2:0]  lead_len;
    seq_keys_t   keys;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign timeout = s_operation;
    assign b       = s_data_byte;

    tkd_seq_map u_seq_map (
        .byte_in      (b),
        .intro_o      (intro_o_reg),
        .digit_byte   (digit_reg),
        .second_digit (second_reg),
        .keys         (keys)
    );

    // UTF-8 gathering arithmetic
    assign acc_shift = {acc_reg[25:0], 6'b0} + {24'b0, b};
    assign rem_dec   = (rem_reg != 3'd0) ? (rem_reg - 3'd1) : 3'd0;
    assign cp_full   = acc_shift - utf8_offset(len_reg);

    // Sequence length from the lead byte
    always_comb begin
        if (b < 8'hE0)      lead_len = 3'd2;
        else if (b < 8'hF0) lead_len = 3'd3;
        else if (b < 8'hF8) lead_len = 3'd4;
        else if (b < 8'hFC) lead_len = 3'd5;
        else                lead_len = 3'd6;
    end

    // Parser step for one transfer
    always_comb begin
        phase_next   = phase_reg;
        intro_o_next = intro_o_reg;
        digit_next   = digit_reg;
        second_next  = second_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        len_next     = len_reg;
        invalid_next = invalid_reg;
        emit         = 1'b0;
        emit_kind    = KEY_IGN;
        emit_cp      = 31'd0;
        emit_fn      = 4'd0;
        idle_work    = 1'b0;

        case (phase_reg)
            PH_IDLE: idle_work = 1'b1;
            PH_ESC: begin
                if (timeout) begin
                    emit = 1'b1;
                    emit_kind = KEY_ESCAPE;
                end else if (b >= 8'h61 && b <= 8'h7A) begin
                    emit = 1'b1;
                end else if (b == CHAR_ESC) begin
                    phase_next = PH_ALT;
                end else if (b == CHAR_LBRK || b == CHAR_UPPER_O) begin
                    intro_o_next = (b == CHAR_UPPER_O);
                    phase_next   = PH_INTRO;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ALT: begin
                if (!timeout && (b == CHAR_LBRK || b == CHAR_UPPER_O)) begin
                    intro_o_next = (b == CHAR_UPPER_O);
                    phase_next   = PH_INTRO;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_INTRO: begin
                if (timeout) begin
                    emit = 1'b1;
                    emit_kind = KEY_ESCAPE;
                end else if (!intro_o_reg && b >= 8'h30 && b <= 8'h39) begin
                    digit_next = b;
                    phase_next = PH_DIGIT;
                end else if (!intro_o_reg && b == CHAR_LBRK) begin
                    phase_next = PH_BRACKET2;
                end else begin
                    emit      = 1'b1;
                    emit_kind = keys.letter.kind;
                    emit_fn   = keys.letter.fn;
                end
            end
            PH_DIGIT: begin
                if (timeout) begin
                    emit = 1'b1;
                    emit_kind = KEY_ESCAPE;
                end else if (b == CHAR_TILDE) begin
                    emit      = 1'b1;
                    emit_kind = keys.tilde.kind;
                end else if (digit_reg == 8'h31 || digit_reg == 8'h32) begin
                    second_next = b;
                    phase_next  = PH_TAIL;
                end else begin
                    emit      = 1'b1;
                    emit_kind = (b == 8'h68) ? KEY_INS : KEY_IGN;
                end
            end
            PH_TAIL: begin
                emit = 1'b1;
                if (timeout) begin
                    emit_kind = KEY_ESCAPE;
                end else begin
                    emit_kind = keys.tail.kind;
                    emit_fn   = keys.tail.fn;
                end
            end
            PH_BRACKET2: begin
                emit = 1'b1;
                if (timeout) begin
                    emit_kind = KEY_ESCAPE;
                end else begin
                    emit_kind = keys.bracket.kind;
                    emit_fn   = keys.bracket.fn;
                end
            end
            PH_UTF8: begin
                if (timeout) begin
                    emit = 1'b1;
                    emit_kind = KEY_ERR;
                end else begin
                    if (b[7:6] != 2'b10) begin
                        invalid_next = 1'b1;
                    end else begin
                        acc_next = acc_shift;
                    end
                    rem_next = rem_dec;
                    if (rem_dec == 3'd0) begin
                        emit = 1'b1;
                        if (invalid_reg || b[7:6] != 2'b10) begin
                            emit_kind = KEY_ERR;
                        end else begin
                            emit_kind = KEY_CHAR;
                            emit_cp   = cp_full[30:0];
                        end
                    end
                end
            end
            default: idle_work = 1'b1;
        endcase

        // Idle: plain bytes, ESC start, UTF-8 lead bytes
        if (idle_work) begin
            phase_next = PH_IDLE;
            if (!timeout) begin
                if (b == CHAR_ESC) begin
                    phase_next = PH_ESC;
                end else if (b == CHAR_DEL) begin
                    emit = 1'b1;
                    emit_kind = KEY_BKSP;
                end else if (b < 8'h80) begin
                    emit      = 1'b1;
                    emit_kind = KEY_CHAR;
                    emit_cp   = {23'd0, b};
                end else if (b < 8'hC0 || b >= 8'hFE) begin
                    emit = 1'b1;
                    emit_kind = KEY_ERR;
                end else begin
                    acc_next     = {24'd0, b};
                    len_next     = lead_len;
                    rem_next     = lead_len - 3'd1;
                    invalid_next = 1'b0;
                    phase_next   = PH_UTF8;
                end
            end
        end

        if (emit) begin
            phase_next = PH_IDLE;
        end
    end

    // Output register: load on a key, drop on a drained transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        cp_next        = cp_reg;
        fn_next        = fn_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept && emit) begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            cp_next        = emit_cp;
            fn_next        = emit_fn;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and sequence context
    always_ff @(posedge aclk) begin
        if (accept) begin
            intro_o_reg <= intro_o_next;
            digit_reg   <= digit_next;
            second_reg  <= second_next;
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            len_reg     <= len_next;
            invalid_reg <= invalid_next;
        end
        kind_reg <= kind_next;
        cp_reg   <= cp_next;
        fn_reg   <= fn_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_key_kind        = kind_reg;
    assign m_code_point      = cp_reg;
    assign m_function_number = fn_reg;

endmodule
